// ===== hw/rtl/normalized_fraction_divider_defines.svh =====
// Assertion macros shared by the divider's checker.
// No dependencies; include once per file that asserts.
`ifndef NORMALIZED_FRACTION_DIVIDER_DEFINES_SVH
`define NORMALIZED_FRACTION_DIVIDER_DEFINES_SVH

// antecedent in a cycle implies consequent in the same cycle
`define NFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define NFD_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nfd_pkg.sv =====
// Constants, stage type and leading-zero count for the fraction divider.
// No dependencies.
package nfd_pkg;

    localparam int unsigned OP_W    = 31;               // operand / quotient width
    localparam int unsigned WORD_W  = 32;               // width the zero count runs over
    localparam int unsigned GUARD   = 8;
    localparam int unsigned STEPS   = OP_W + GUARD;     // restoring steps
    localparam int unsigned REM_W   = OP_W + GUARD;     // normalized remainder / divisor
    localparam int unsigned QUO_W   = STEPS + 1;        // raw quotient
    localparam int unsigned LZC_W   = 6;
    localparam int unsigned SH_W    = 6;
    localparam int unsigned LATENCY = STEPS + 4;        // accept edge to result edge

    localparam logic [OP_W-1:0] Q31_MAX = {OP_W{1'b1}};

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dsr;
        logic [QUO_W-1:0] quo;
        logic [SH_W-1:0]  sh;    // final right shift
        logic             sat;   // dividend >= divisor
        logic             oor;   // dividend > divisor
        logic             zero;  // dividend == 0
    } t_stage;

    function automatic logic [3:0] lzc8(input logic [7:0] v);
        logic [3:0] n;
        logic       hit;
        n   = 4'd8;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 4'(7 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [LZC_W-1:0] lzc32(input logic [WORD_W-1:0] v);
        logic [LZC_W-1:0] n;
        if (v[31:24] != 8'h00) begin
            n = {2'b00, lzc8(v[31:24])};
        end else if (v[23:16] != 8'h00) begin
            n = 6'd8 + {2'b00, lzc8(v[23:16])};
        end else if (v[15:8] != 8'h00) begin
            n = 6'd16 + {2'b00, lzc8(v[15:8])};
        end else if (v[7:0] != 8'h00) begin
            n = 6'd24 + {2'b00, lzc8(v[7:0])};
        end else begin
            n = 6'd32;
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/normalized_fraction_divider.sv =====
// Pipelined Q31 fraction divider: normalize, 39 restoring steps, denormalize.
// Depends on nfd_pkg.
//
// Usage:
//   Request channel: drive i_dividend, i_divisor and raise start. A request is
//   taken at every rising edge with start high and busy low; busy is low
//   whenever the block is out of reset, so a new request may enter every cycle.
//   Result channel: o_done is high for one cycle with o_quotient and
//   o_out_of_range; the receiver must take it then.
//   Pipeline: a request taken at an edge passes the input reg, the zero
//   count, normalize, one stage per restoring step and the output shift,
//   where its result is strobed. Throughput is one request per cycle.
//   Quotient is dividend/divisor as an unsigned Q31 fraction. Equal operands
//   give 0x7FFFFFFF. A dividend above the divisor gives 0x7FFFFFFF with
//   o_out_of_range set. A zero dividend with a nonzero divisor gives zero.
//   Reset (i_rst_n low, synchronous) drops every request in flight and holds
//   busy high; payload registers are not cleared.
module normalized_fraction_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [nfd_pkg::OP_W-1:0]  i_dividend,
    input  logic [nfd_pkg::OP_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [nfd_pkg::OP_W-1:0]  o_quotient,
    output logic                      o_out_of_range
);

    // input register
    logic                     r_va;
    logic [nfd_pkg::OP_W-1:0] r_a_dvd;
    logic [nfd_pkg::OP_W-1:0] r_a_dsr;

    // zero-count stage
    logic                      r_vb;
    logic [nfd_pkg::OP_W-1:0]  r_b_dvd;
    logic [nfd_pkg::OP_W-1:0]  r_b_dsr;
    logic [nfd_pkg::LZC_W-1:0] r_b_za;
    logic [nfd_pkg::LZC_W-1:0] r_b_zb;
    logic                      r_b_sat;
    logic                      r_b_oor;
    logic                      r_b_zero;

    // restoring stages; r_stg[0] holds the normalized operands
    nfd_pkg::t_stage r_stg [0:nfd_pkg::STEPS];
    logic            r_vld [0:nfd_pkg::STEPS];

    nfd_pkg::t_stage            n_stg0;
    logic [4:0]                 norm_a;
    logic [4:0]                 norm_b;
    logic [nfd_pkg::OP_W-1:0]   na;
    logic [nfd_pkg::OP_W-1:0]   nb;
    logic [nfd_pkg::QUO_W-1:0]  shifted;
    logic [nfd_pkg::OP_W-1:0]   n_quotient;

    assign busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= start;
        end
        r_a_dvd <= i_dividend;
        r_a_dsr <= i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_b_dvd  <= r_a_dvd;
        r_b_dsr  <= r_a_dsr;
        r_b_za   <= nfd_pkg::lzc32({1'b0, r_a_dvd});
        r_b_zb   <= nfd_pkg::lzc32({1'b0, r_a_dsr});
        r_b_sat  <= r_a_dvd >= r_a_dsr;
        r_b_oor  <= r_a_dvd > r_a_dsr;
        r_b_zero <= r_a_dvd == '0;
    end

    // normalize so bit 30 is set, then append the guard bits
    always_comb begin
        norm_a      = 5'(r_b_za - 6'd1);
        norm_b      = 5'(r_b_zb - 6'd1);
        na          = r_b_dvd << norm_a;
        nb          = r_b_dsr << norm_b;
        n_stg0.rem  = {na, {nfd_pkg::GUARD{1'b0}}};
        n_stg0.dsr  = {nb, {nfd_pkg::GUARD{1'b0}}};
        n_stg0.quo  = '0;
        n_stg0.sh   = nfd_pkg::SH_W'(r_b_za - r_b_zb + 6'(nfd_pkg::GUARD));
        n_stg0.sat  = r_b_sat;
        n_stg0.oor  = r_b_oor;
        n_stg0.zero = r_b_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_vb;
        end
        r_stg[0] <= n_stg0;
    end

    for (genvar k = 0; k < nfd_pkg::STEPS; k++) begin : g_step
        logic            ge;
        nfd_pkg::t_stage n_stg;

        always_comb begin
            ge    = r_stg[k].rem >= r_stg[k].dsr;
            n_stg = r_stg[k];
            if (ge) begin
                n_stg.rem = r_stg[k].rem - r_stg[k].dsr;
            end
            // add the step bit, then shift the quotient up
            n_stg.quo = {r_stg[k].quo[nfd_pkg::QUO_W-2:1], ge, 1'b0};
            n_stg.dsr = r_stg[k].dsr >> 1;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_stg[k+1] <= n_stg;
        end
    end

    always_comb begin
        shifted = r_stg[nfd_pkg::STEPS].quo >> r_stg[nfd_pkg::STEPS].sh;
        if (r_stg[nfd_pkg::STEPS].sat) begin
            n_quotient = nfd_pkg::Q31_MAX;
        end else if (r_stg[nfd_pkg::STEPS].zero) begin
            n_quotient = '0;
        end else begin
            n_quotient = shifted[nfd_pkg::OP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_vld[nfd_pkg::STEPS];
        end
        o_quotient     <= n_quotient;
        o_out_of_range <= r_stg[nfd_pkg::STEPS].oor;
    end

endmodule

// ===== hw/rtl/nfd_checker.sv =====
// Port-level checks for the fraction divider, bound to its top level.
// Depends on nfd_pkg and normalized_fraction_divider_defines.svh.
`include "normalized_fraction_divider_defines.svh"

module nfd_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [nfd_pkg::OP_W-1:0] i_dividend,
    input logic [nfd_pkg::OP_W-1:0] i_divisor,
    input logic                     o_done,
    input logic [nfd_pkg::OP_W-1:0] o_quotient,
    input logic                     o_out_of_range
);

    logic req;
    assign req = start && !busy;

    // every taken request comes out exactly once, after the fixed latency
    `NFD_ASSERT_DELAY(a_req_done, i_clk, i_rst_n, req, nfd_pkg::LATENCY, o_done, "request lost")
    `NFD_ASSERT_IMPL(a_done_req, i_clk, i_rst_n, o_done, $past(req, nfd_pkg::LATENCY), "spurious result")
    `NFD_ASSERT_IMPL(a_oor, i_clk, i_rst_n, o_done,
        o_out_of_range == $past(i_dividend > i_divisor, nfd_pkg::LATENCY), "range flag wrong")
    `NFD_ASSERT_IMPL(a_sat, i_clk, i_rst_n, o_done && o_out_of_range,
        o_quotient == nfd_pkg::Q31_MAX, "out of range result not saturated")
    `NFD_ASSERT_IMPL(a_zero, i_clk, i_rst_n,
        o_done && $past(i_dividend == '0 && i_divisor != '0, nfd_pkg::LATENCY),
        o_quotient == '0, "zero dividend gave nonzero quotient")

endmodule

bind normalized_fraction_divider nfd_checker u_nfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_dividend     (i_dividend),
    .i_divisor      (i_divisor),
    .o_done         (o_done),
    .o_quotient     (o_quotient),
    .o_out_of_range (o_out_of_range)
);
